// File: sv/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types, constants and color math for the heat map colorizer.
// ----------------------------------------------------------------------------
package dhc_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_SEGMENTS  = 16;
  localparam int DEF_MAX_ROW_WIDTH = 4096;

  // Queue depths between the parts
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Configuration register indexes
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_SEG_COUNT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_SEG = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW_WIDTH  = 2'd2;

  // Register widths
  localparam int SEG_COUNT_W  = 5;
  localparam int ACTIVE_SEG_W = 4;
  localparam int ROW_WIDTH_W  = 13;
  localparam int CFG_DATA_W   = 13;

  // Sample and color constants
  localparam int SAMPLE_W = 16;
  localparam logic [16:0] FULL_SCALE = 17'h0FFFF;
  localparam logic [5:0]  RB_MAX     = 6'h1F;
  localparam logic [5:0]  G_MAX      = 6'h3F;
  localparam int GRAD_LEN = 8;

  // Gradient endpoint bits, bit i is entry i:
  // black, red, yellow, green, cyan, blue, blue, white
  localparam logic [GRAD_LEN-1:0] GRAD_R = 8'b1000_0110;
  localparam logic [GRAD_LEN-1:0] GRAD_G = 8'b1001_1100;
  localparam logic [GRAD_LEN-1:0] GRAD_B = 8'b1111_0000;

  // Request from the front part to the back part
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                row_end;
  } mid_item_t;

  // Finished pixel
  typedef struct packed {
    logic [15:0] pixel_color;
    logic        row_end;
  } out_item_t;

  // Gradient position after the first color stage
  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] rem;
    logic        row_end;
  } grad_pos_t;

  // One channel: blend endpoint bits a, b by rem / 65535 at full scale m
  function automatic logic [5:0] blend_chan(input logic a, input logic b,
                                            input logic [15:0] rem,
                                            input logic [5:0] m);
    logic [21:0] prod;
    logic [16:0] part;
    logic        wrap;
    logic [16:0] left;
    logic [5:0]  flo;
    logic [5:0]  cei;
    logic [5:0]  res;
    // rem*m / 65535 via 65536 = 65535 + 1, one correction step
    prod = 22'(rem) * 22'(m);
    part = 17'(prod[21:16]) + 17'(prod[15:0]);
    wrap = (part >= FULL_SCALE);
    left = wrap ? (part - FULL_SCALE) : part;
    flo  = prod[21:16] + 6'(wrap);
    cei  = flo + 6'(left != 17'd0);
    case ({a, b})
      2'b00:   res = 6'd0;
      2'b01:   res = flo;
      2'b10:   res = m - cei;
      default: res = m;
    endcase
    return res;
  endfunction

  // RGB565 color from gradient index and remainder
  function automatic logic [15:0] heat_color(input logic [2:0] idx,
                                             input logic [15:0] rem);
    logic [2:0] hi;
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    hi = (idx == 3'd7) ? 3'd7 : idx + 3'd1;
    r  = blend_chan(GRAD_R[idx], GRAD_R[hi], rem, RB_MAX);
    g  = blend_chan(GRAD_G[idx], GRAD_G[hi], rem, G_MAX);
    b  = blend_chan(GRAD_B[idx], GRAD_B[hi], rem, RB_MAX);
    return {r[4:0], g, b[4:0]};
  endfunction

endpackage

// File: sv/dhc_fifo.sv
// ----------------------------------------------------------------------------
// dhc_fifo
// Small register queue with full and empty flags taken from a fill count.
// ----------------------------------------------------------------------------
module dhc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/dhc_front.sv
// ----------------------------------------------------------------------------
// dhc_front
// Configuration registers, segment phase and column tracking; forwards kept
// samples with their row end flag.
// ----------------------------------------------------------------------------
module dhc_front #(
  parameter int MAX_SEGMENTS  = dhc_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_ROW_WIDTH = dhc_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [dhc_pkg::SAMPLE_W-1:0]   sample,
  input  logic                           q_full,
  input  logic                           wr_en,
  input  logic [dhc_pkg::IDX_W-1:0]      wr_index,
  input  logic [dhc_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                           q_push,
  output dhc_pkg::mid_item_t             q_item
);

  localparam int PW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int COLW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int SCW  = ((PW > dhc_pkg::SEG_COUNT_W) ? PW : dhc_pkg::SEG_COUNT_W) + 1;
  localparam int RCW  = ((COLW > dhc_pkg::ROW_WIDTH_W) ? COLW : dhc_pkg::ROW_WIDTH_W) + 1;

  logic [dhc_pkg::SEG_COUNT_W-1:0]  seg_count;
  logic [dhc_pkg::ACTIVE_SEG_W-1:0] active_seg;
  logic [dhc_pkg::ROW_WIDTH_W-1:0]  row_width;
  logic [PW-1:0]                    phase;
  logic [COLW-1:0]                  column;

  logic [dhc_pkg::SEG_COUNT_W-1:0]  count_eff;
  logic [dhc_pkg::ROW_WIDTH_W-1:0]  width_eff;
  logic                             accept;
  logic                             keep;
  logic                             last;
  logic                             phase_wrap;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count  <= dhc_pkg::SEG_COUNT_W'(1);
      active_seg <= '0;
      row_width  <= dhc_pkg::ROW_WIDTH_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        dhc_pkg::REG_SEG_COUNT:  seg_count  <= wr_data[dhc_pkg::SEG_COUNT_W-1:0];
        dhc_pkg::REG_ACTIVE_SEG: active_seg <= wr_data[dhc_pkg::ACTIVE_SEG_W-1:0];
        dhc_pkg::REG_ROW_WIDTH:  row_width  <= wr_data;
        default: ;
      endcase
    end
  end

  // effective count and width after saturation; zero width acts as one
  always_comb begin
    if (32'(seg_count) > MAX_SEGMENTS) begin
      count_eff = dhc_pkg::SEG_COUNT_W'(MAX_SEGMENTS);
    end else begin
      count_eff = seg_count;
    end
    if (row_width == '0) begin
      width_eff = dhc_pkg::ROW_WIDTH_W'(1);
    end else if (32'(row_width) > MAX_ROW_WIDTH) begin
      width_eff = dhc_pkg::ROW_WIDTH_W'(MAX_ROW_WIDTH);
    end else begin
      width_eff = row_width;
    end
  end

  // classify the request
  assign accept     = push && !q_full;
  assign keep       = (count_eff != '0) && (SCW'(active_seg) < SCW'(count_eff)) &&
                      (SCW'(phase) == SCW'(active_seg));
  assign last       = (RCW'(column) + RCW'(1)) >= RCW'(width_eff);
  assign phase_wrap = (count_eff == '0) || ((SCW'(phase) + SCW'(1)) >= SCW'(count_eff));

  assign q_push         = accept && keep;
  assign q_item.sample  = sample;
  assign q_item.row_end = last;

  // phase and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      column <= '0;
    end else if (accept) begin
      phase <= phase_wrap ? '0 : phase + 1'b1;
      if (keep) begin
        column <= last ? '0 : column + 1'b1;
      end
    end
  end

endmodule

// File: sv/dhc_back.sv
// ----------------------------------------------------------------------------
// dhc_back
// Two-step colorizer: gradient index and remainder, then RGB565 blend.
// ----------------------------------------------------------------------------
module dhc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  dhc_pkg::mid_item_t q_item,
  output logic               q_pop,
  input  logic               o_full,
  output logic               o_push,
  output dhc_pkg::out_item_t o_item
);

  logic               s1_vld;
  dhc_pkg::grad_pos_t s1;
  dhc_pkg::grad_pos_t s1_next;
  logic               s1_go;
  logic [18:0]        scaled;
  logic [16:0]        part;
  logic               wrap;

  // sample*7 split into index and remainder of 65535
  always_comb begin
    scaled          = {q_item.sample, 3'b000} - 19'(q_item.sample);
    part            = 17'(scaled[18:16]) + 17'(scaled[15:0]);
    wrap            = (part >= dhc_pkg::FULL_SCALE);
    s1_next.idx     = scaled[18:16] + 3'(wrap);
    s1_next.rem     = wrap ? 16'(part - dhc_pkg::FULL_SCALE) : part[15:0];
    s1_next.row_end = q_item.row_end;
  end

  // stage handshake
  assign s1_go = s1_vld && !o_full;
  assign q_pop = !q_empty && (!s1_vld || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (q_pop) begin
      s1_vld <= 1'b1;
    end else if (s1_go) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= s1_next;
    end
  end

  // blend step into the result queue
  assign o_push             = s1_go;
  assign o_item.pixel_color = dhc_pkg::heat_color(s1.idx, s1.rem);
  assign o_item.row_end     = s1.row_end;

endmodule

// File: sv/deinterlace_heatmap_colorizer.sv
// ----------------------------------------------------------------------------
// deinterlace_heatmap_colorizer
// Keeps one segment of an interleaved 16-bit sample stream and turns each
// kept sample into an RGB565 heat map pixel with a row end flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive sample and push; a request is taken when push is high
//   and full is low. Every taken sample steps the segment phase; only samples
//   in the active segment produce a pixel.
//   Result queue: while empty is low, pixel_color and row_end show the oldest
//   pixel; pop takes it.
//   Configuration: wr_en, wr_index and wr_data write segment_count (0),
//   active_segment (1) and row_width (2); write only while idle.
// Timing:
//   One sample per clock sustained while pop keeps the result queue drained. A
//   kept sample is registered in the front queue, the index stage, then the result queue.
// Reset (rst, synchronous): registers return to count 1, segment 0, width 1;
//   phase and column clear; both queues empty.
// Stall: when pop is held low the result queue fills, the index stage holds,
//   then the front queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module deinterlace_heatmap_colorizer #(
  parameter int MAX_SEGMENTS  = dhc_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_ROW_WIDTH = dhc_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [dhc_pkg::SAMPLE_W-1:0]   sample,
  output logic                           empty,
  input  logic                           pop,
  output logic [15:0]                    pixel_color,
  output logic                           row_end,
  input  logic                           wr_en,
  input  logic [dhc_pkg::IDX_W-1:0]      wr_index,
  input  logic [dhc_pkg::CFG_DATA_W-1:0] wr_data
);

  logic               mid_push;
  dhc_pkg::mid_item_t mid_wr;
  dhc_pkg::mid_item_t mid_rd;
  logic               mid_full;
  logic               mid_empty;
  logic               mid_pop;
  logic               out_push;
  dhc_pkg::out_item_t out_wr;
  dhc_pkg::out_item_t out_rd;
  logic               out_full;

  assign full        = mid_full;
  assign pixel_color = out_rd.pixel_color;
  assign row_end     = out_rd.row_end;

  // front: config, phase filter, column tracking
  dhc_front #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .q_full   (mid_full),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .q_push   (mid_push),
    .q_item   (mid_wr)
  );

  // queue between front and back
  dhc_fifo #(
    .WIDTH ($bits(dhc_pkg::mid_item_t)),
    .DEPTH (dhc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  // back: color computation
  dhc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mid_empty),
    .q_item  (mid_rd),
    .q_pop   (mid_pop),
    .o_full  (out_full),
    .o_push  (out_push),
    .o_item  (out_wr)
  );

  // result queue
  dhc_fifo #(
    .WIDTH ($bits(dhc_pkg::out_item_t)),
    .DEPTH (dhc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wr),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rd),
    .empty (empty)
  );

endmodule

// File: sim/deinterlace_heatmap_colorizer_tb.sv
// ----------------------------------------------------------------------------
// deinterlace_heatmap_colorizer_tb
// Self-checking bench for the heat map colorizer. A short scripted sequence
// covers the color extremes, gradient boundaries and the odd register
// settings, then randomized register settings are each followed by a stream
// of samples. Every accepted sample goes through a local model of the segment
// phase, the column counter and the RGB565 gradient, and every popped pixel
// is compared with the oldest predicted one. Both sides idle at random.
// ----------------------------------------------------------------------------
module deinterlace_heatmap_colorizer_tb;

  // Register index with no register behind it
  localparam logic [dhc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  // Gradient math
  localparam int unsigned SPAN     = 65535;
  localparam int unsigned TOP_STOP = 7;
  localparam int unsigned RB_FULL  = 31;
  localparam int unsigned G_FULL   = 63;
  // Stop bits, bit i is gradient entry i:
  // black, red, yellow, green, cyan, blue, blue, white
  localparam logic [7:0] RED_STOPS   = 8'b1000_0110;
  localparam logic [7:0] GREEN_STOPS = 8'b1001_1100;
  localparam logic [7:0] BLUE_STOPS  = 8'b1111_0000;

  // Run control
  localparam int RANDOM_ITEMS = 750;
  localparam int SETTLE       = 8;
  localparam int LIMIT_CYCLES = 400000;

  // Scripted sequence
  typedef enum logic {DO_SAMPLE, DO_WRITE} row_kind_t;
  typedef struct packed {
    row_kind_t                 kind;
    logic [dhc_pkg::IDX_W-1:0] idx;   // register for writes, unused for samples
    logic [15:0]               value; // sample, or write data in bits 12..0
    logic                      typed; // expected pixel given below
    logic [15:0]               exp_color;
    logic                      exp_row_end;
  } row_t;

  localparam int NROWS = 38;
  row_t script [NROWS] = '{
    // reset settings: every sample kept, every pixel ends a row
    '{DO_SAMPLE, REG_UNUSED,              16'h0000, 1'b1, 16'h0000, 1'b1},
    '{DO_SAMPLE, REG_UNUSED,              16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
    '{DO_SAMPLE, REG_UNUSED,              16'h0001, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hFFFE, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h2492, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h2493, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h5555, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hAAAA, 1'b0, 16'h0000, 1'b0},
    // three segments, keep the middle one, rows of three
    '{DO_WRITE,  dhc_pkg::REG_ROW_WIDTH,  16'h0003, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_SEG_COUNT,  16'h0003, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ACTIVE_SEG, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h8000, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h1234, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h4000, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h6DB6, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h9249, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hC000, 1'b0, 16'h0000, 1'b0},
    // width lowered below the current column
    '{DO_WRITE,  dhc_pkg::REG_ROW_WIDTH,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hDB6D, 1'b0, 16'h0000, 1'b0},
    // zero segment count
    '{DO_WRITE,  dhc_pkg::REG_SEG_COUNT,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h0F0F, 1'b0, 16'h0000, 1'b0},
    // count saturates, zero width acts as one
    '{DO_WRITE,  dhc_pkg::REG_SEG_COUNT,  16'h1FFF, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ACTIVE_SEG, 16'h0002, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ROW_WIDTH,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h3333, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hCCCC, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hF00D, 1'b0, 16'h0000, 1'b0},
    // count lowered under the phase, active segment out of range
    '{DO_WRITE,  dhc_pkg::REG_SEG_COUNT,  16'h0002, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ACTIVE_SEG, 16'h0005, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h00FF, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hFF00, 1'b0, 16'h0000, 1'b0},
    // write to a missing register, width saturates
    '{DO_WRITE,  REG_UNUSED,              16'h1FFF, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ROW_WIDTH,  16'h1FFF, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_ACTIVE_SEG, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{DO_WRITE,  dhc_pkg::REG_SEG_COUNT,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'h0000, 1'b0, 16'h0000, 1'b0},
    '{DO_SAMPLE, REG_UNUSED,              16'hFFFF, 1'b0, 16'h0000, 1'b0}
  };

  // DUT signals
  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           push     = 1'b0;
  logic                           full;
  logic [dhc_pkg::SAMPLE_W-1:0]   sample   = '0;
  logic                           empty;
  logic                           pop      = 1'b0;
  logic [15:0]                    pixel_color;
  logic                           row_end;
  logic                           wr_en    = 1'b0;
  logic [dhc_pkg::IDX_W-1:0]      wr_index = dhc_pkg::REG_SEG_COUNT;
  logic [dhc_pkg::CFG_DATA_W-1:0] wr_data  = '0;

  // Local copy of registers and counters
  logic [dhc_pkg::SEG_COUNT_W-1:0]  cfg_seg_count  = 5'd1;
  logic [dhc_pkg::ACTIVE_SEG_W-1:0] cfg_active_seg = 4'd0;
  logic [dhc_pkg::ROW_WIDTH_W-1:0]  cfg_row_width  = 13'd1;
  logic [3:0]                       seg_phase      = 4'd0;
  logic [11:0]                      col_pos        = 12'd0;

  // Pixels predicted but not yet popped
  dhc_pkg::out_item_t pending_pixels [$];

  int mismatches    = 0;
  int pixels_seen   = 0;
  int row_ends_seen = 0;
  int samples_sent  = 0;
  int settings_used = 0;
  int cycles        = 0;
  logic [15:0] rx_cycle = '0;

  deinterlace_heatmap_colorizer dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .empty       (empty),
    .pop         (pop),
    .pixel_color (pixel_color),
    .row_end     (row_end),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always #2 clk = ~clk;

  // One channel: stop bits a, b weighted by frac / SPAN, floored at full scale
  function automatic int unsigned mix_channel(input logic a, input logic b,
                                              input int unsigned frac,
                                              input int unsigned full_scale);
    int unsigned mix;
    mix = (a ? SPAN - frac : 0) + (b ? frac : 0);
    return (mix * full_scale) / SPAN;
  endfunction

  // Sample to RGB565 heat color
  function automatic logic [15:0] heat_rgb565(input logic [15:0] s);
    int unsigned scaled, lo, hi, frac, r, g, b;
    scaled = 32'(s) * TOP_STOP;
    lo     = scaled / SPAN;
    frac   = scaled % SPAN;
    hi     = (lo == TOP_STOP) ? TOP_STOP : lo + 1;
    r = mix_channel(RED_STOPS[lo], RED_STOPS[hi], frac, RB_FULL);
    g = mix_channel(GREEN_STOPS[lo], GREEN_STOPS[hi], frac, G_FULL);
    b = mix_channel(BLUE_STOPS[lo], BLUE_STOPS[hi], frac, RB_FULL);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Step phase and column for one accepted sample; queue the pixel if kept
  function automatic bit track_sample(input logic [15:0] s);
    int unsigned        cnt, wid;
    dhc_pkg::out_item_t px;
    bit                 keep;
    cnt = (cfg_seg_count > dhc_pkg::DEF_MAX_SEGMENTS) ?
          dhc_pkg::DEF_MAX_SEGMENTS : 32'(cfg_seg_count);
    wid = (cfg_row_width == 0) ? 1 :
          (cfg_row_width > dhc_pkg::DEF_MAX_ROW_WIDTH) ?
          dhc_pkg::DEF_MAX_ROW_WIDTH : 32'(cfg_row_width);
    keep = (cnt != 0) && (cfg_active_seg < cnt) && (seg_phase == cfg_active_seg);
    if (keep) begin
      px.pixel_color = heat_rgb565(s);
      px.row_end     = (col_pos + 1 >= wid);
      col_pos        = px.row_end ? 12'd0 : col_pos + 12'd1;
      pending_pixels.push_back(px);
    end
    // phase also wraps when the count was lowered under it
    seg_phase = (cnt == 0 || seg_phase + 1 >= cnt) ? 4'd0 : seg_phase + 4'd1;
    return keep;
  endfunction

  // Register write; wr_en stays high until the next sample send drops it
  task automatic write_reg(input logic [dhc_pkg::IDX_W-1:0] idx,
                           input logic [dhc_pkg::CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    case (idx)
      dhc_pkg::REG_SEG_COUNT:  cfg_seg_count  = d[dhc_pkg::SEG_COUNT_W-1:0];
      dhc_pkg::REG_ACTIVE_SEG: cfg_active_seg = d[dhc_pkg::ACTIVE_SEG_W-1:0];
      dhc_pkg::REG_ROW_WIDTH:  cfg_row_width  = d[dhc_pkg::ROW_WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  // Push one sample request and wait until it is taken
  task automatic send_sample(input logic [15:0] s, output bit made);
    wr_en  <= 1'b0;
    push   <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    made = track_sample(s);
    samples_sent++;
  endtask

  // Stop sending, let every predicted pixel drain, then let the pipe settle
  task automatic quiesce();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Samples for one register setting, sent in bursts with random gaps
  task automatic run_setting(input int n);
    int          left, burst, gap, k;
    logic [15:0] s;
    bit          made;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) begin
        case ($urandom_range(0, 15))
          0: s = 16'h0000;
          1: s = 16'hFFFF;
          2: begin
            // straddle a gradient stop
            k = $urandom_range(1, 6);
            s = 16'((k * SPAN + 6) / 7 - 1 + $urandom_range(0, 2));
          end
          default: s = 16'($urandom());
        endcase
        send_sample(s, made);
      end
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (left > 0 && $urandom_range(0, 39) == 0) begin
        // hold off until the result side has caught up
        push <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
      end else if (left > 0 && gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result side stalls: free flow, coin flip, heavy stall, fixed duty pattern
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= 1'($urandom_range(0, 1));
        2'd2:    pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (rx_cycle[3:0] < 4'd10);
      endcase
    end
  end

  // Pixel checker and watchdog
  always @(posedge clk) begin
    dhc_pkg::out_item_t want;
    cycles++;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_color %h row_end %b", pixel_color, row_end);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_seen++;
        if (want.row_end) row_ends_seen++;
        if (pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, got %h", want.pixel_color, pixel_color);
          mismatches++;
        end
        if (row_end !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, row_end);
          mismatches++;
        end
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $error("timeout with %0d pixels still pending", pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit                             made;
    bit                             busy;
    int                             random_items;
    int                             cnt, act, wid;
    logic [dhc_pkg::CFG_DATA_W-1:0] d;

    busy         = 1'b0;
    random_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // scripted part
    for (int i = 0; i < NROWS; i++) begin
      if (script[i].kind == DO_WRITE) begin
        if (busy) begin
          quiesce();
          busy = 1'b0;
          settings_used++;
        end
        write_reg(script[i].idx, script[i].value[dhc_pkg::CFG_DATA_W-1:0]);
      end else begin
        send_sample(script[i].value, made);
        busy = 1'b1;
        if (script[i].typed && made) begin
          pending_pixels[pending_pixels.size()-1].pixel_color = script[i].exp_color;
          pending_pixels[pending_pixels.size()-1].row_end     = script[i].exp_row_end;
        end
      end
    end

    // random settings, each followed by a sample stream
    while (random_items < RANDOM_ITEMS) begin
      quiesce();
      settings_used++;
      case ($urandom_range(0, 9))
        0: begin
          cnt = 0;
          act = $urandom_range(0, 15);
        end
        1: begin
          cnt = $urandom_range(17, 31);
          act = $urandom_range(0, 15);
        end
        2: begin
          // active segment at or above the count
          cnt = $urandom_range(1, 15);
          act = $urandom_range(cnt, 15);
        end
        default: begin
          cnt = $urandom_range(1, 16);
          act = $urandom_range(0, cnt - 1);
        end
      endcase
      case ($urandom_range(0, 9))
        0:       wid = 0;
        1:       wid = dhc_pkg::DEF_MAX_ROW_WIDTH;
        2:       wid = $urandom_range(dhc_pkg::DEF_MAX_ROW_WIDTH + 1, 8191);
        3:       wid = $urandom_range(1, dhc_pkg::DEF_MAX_ROW_WIDTH);
        default: wid = $urandom_range(1, 8);
      endcase
      // unused upper data bits carry noise
      d = 13'($urandom());
      d[dhc_pkg::SEG_COUNT_W-1:0] = 5'(cnt);
      write_reg(dhc_pkg::REG_SEG_COUNT, d);
      d = 13'($urandom());
      d[dhc_pkg::ACTIVE_SEG_W-1:0] = 4'(act);
      write_reg(dhc_pkg::REG_ACTIVE_SEG, d);
      if ($urandom_range(0, 7) != 0) write_reg(dhc_pkg::REG_ROW_WIDTH, 13'(wid));
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 13'($urandom()));
      wid = $urandom_range(10, 60);
      run_setting(wid);
      random_items += wid;
    end

    quiesce();
    $display("Run: %0d samples over %0d register settings, %0d pixels checked (%0d row ends).",
             samples_sent, settings_used, pixels_seen, row_ends_seen);
    $display("Settings spanned zero, saturated and out-of-range counts, segments and widths.");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
